>>> src/wssm_pkg.sv
// ----------------------------------------------------------------------------
// wssm_pkg
// Shared types and constants for the weight-stationary systolic matmul core.
// ----------------------------------------------------------------------------
package wssm_pkg;

   localparam int BYTE_W = 8;
   localparam int SUM_W  = 32;
   localparam int WORD_W = 32;

   // request mode codes; the fourth code does nothing
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_QUEUE  = 2'd1;
   localparam logic [1:0] MODE_STREAM = 2'd2;

   // one accepted request, decoded
   typedef struct packed {
      logic load;
      logic queue;
      logic stream;
      logic group;
   } step_type;

   // per-cell strobes
   typedef struct packed {
      logic beat;
      logic wt_load;
   } cell_ctrl_type;

endpackage

>>> src/wssm_cell.sv
// ----------------------------------------------------------------------------
// wssm_cell
// One processing element: stationary weight, input byte (held except in the
// first column) and 32-bit partial sum passed down the column.
// ----------------------------------------------------------------------------
module wssm_cell #(
   parameter bit FIRST_COL = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wssm_pkg::cell_ctrl_type       ctrl,
   input  logic [wssm_pkg::BYTE_W-1:0]   wt_byte,
   input  logic [wssm_pkg::BYTE_W-1:0]   act_left,
   input  logic [wssm_pkg::SUM_W-1:0]    sum_above,
   output logic [wssm_pkg::BYTE_W-1:0]   act_out,
   output logic [wssm_pkg::SUM_W-1:0]    sum_out,
   output logic [wssm_pkg::BYTE_W-1:0]   sum_lo_in
);

   logic [wssm_pkg::BYTE_W-1:0] w_ff;
   logic [wssm_pkg::BYTE_W-1:0] act;
   logic signed [2*wssm_pkg::BYTE_W-1:0] prod;
   logic [wssm_pkg::SUM_W-1:0]  sum_ff;
   logic [wssm_pkg::SUM_W-1:0]  sum_in;

   // the leftmost cell works on the byte leaving the skew line this beat
   generate
      if (FIRST_COL) begin : g_first
         assign act = act_left;
      end else begin : g_inner
         logic [wssm_pkg::BYTE_W-1:0] act_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               act_ff <= '0;
            end else if (ctrl.beat) begin
               act_ff <= act_left;
            end
         end
         assign act = act_ff;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else if (ctrl.wt_load) begin
         w_ff <= wt_byte;
      end
   end

   assign prod   = $signed(act) * $signed(w_ff);
   assign sum_in = {{(wssm_pkg::SUM_W-2*wssm_pkg::BYTE_W){prod[2*wssm_pkg::BYTE_W-1]}}, prod}
                   + sum_above;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.beat) begin
         sum_ff <= sum_in;
      end
   end

   assign act_out   = act;
   assign sum_out   = sum_ff;
   assign sum_lo_in = sum_in[wssm_pkg::BYTE_W-1:0];

endmodule

>>> src/wssm_skew.sv
// ----------------------------------------------------------------------------
// wssm_skew
// Input skew line: row r is written on its diagonal and reaches the array
// r beats later.
// ----------------------------------------------------------------------------
module wssm_skew #(
   parameter int ARRAY_DIM      = 8,
   parameter int BYTES_PER_WORD = 4,
   parameter int GROUPS         = 2
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  wssm_pkg::step_type                          step,
   input  logic [wssm_pkg::WORD_W-1:0]                 data_word,
   output logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0]  feed
);

   genvar r;
   generate
      for (r = 0; r < ARRAY_DIM; r++) begin : g_row
         localparam int GRP  = r / BYTES_PER_WORD;
         localparam int POS  = r % BYTES_PER_WORD;
         localparam int WCOL = ARRAY_DIM - 1 - r;

         logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0] row_ff;
         logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0] eff;
         logic                                        wr;

         assign wr = (step.stream && (GRP == GROUPS - 1))
                  || (step.queue && (step.group ? (GRP == 1) : (GRP == 0)));

         always_comb begin
            eff = row_ff;
            if (wr) begin
               eff[WCOL] = data_word[wssm_pkg::BYTE_W*(BYTES_PER_WORD-1-POS) +: wssm_pkg::BYTE_W];
            end
         end

         // column zero keeps its value across a shift
         always_ff @(posedge clock) begin
            if (reset) begin
               row_ff <= '0;
            end else if (step.stream) begin
               row_ff[0]             <= eff[0];
               row_ff[ARRAY_DIM-1:1] <= eff[ARRAY_DIM-2:0];
            end else if (step.queue) begin
               row_ff <= eff;
            end
         end

         assign feed[r] = eff[ARRAY_DIM-1];
      end
   endgenerate

endmodule

>>> src/wssm_deskew.sv
// ----------------------------------------------------------------------------
// wssm_deskew
// Output deskew line: low bytes of the bottom sums travel down one line per
// column; the anti-diagonal holds the aligned outputs.
// ----------------------------------------------------------------------------
module wssm_deskew #(
   parameter int ARRAY_DIM = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        beat,
   input  logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0]  bottom_lo,
   output logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0]  diag_cur,
   output logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0]  diag_next
);

   genvar c;
   generate
      for (c = 0; c < ARRAY_DIM; c++) begin : g_col
         logic [ARRAY_DIM-1:0][wssm_pkg::BYTE_W-1:0] line_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               line_ff <= '0;
            end else if (beat) begin
               line_ff <= {line_ff[ARRAY_DIM-2:0], bottom_lo[c]};
            end
         end

         assign diag_cur[c] = line_ff[ARRAY_DIM-1-c];

         // value the diagonal takes after this beat
         if (c == ARRAY_DIM - 1) begin : g_top
            assign diag_next[c] = bottom_lo[c];
         end else begin : g_deep
            assign diag_next[c] = line_ff[ARRAY_DIM-2-c];
         end
      end
   endgenerate

endmodule

>>> src/weight_stationary_systolic_matmul_core.sv
// ----------------------------------------------------------------------------
// weight_stationary_systolic_matmul_core
// Weight-stationary int8 systolic array with input skew and output deskew.
//
//  channel  direction  ports                                         transfer
//  req      in         req_mode req_weight_row req_column_group       valid&ready
//                      req_data_word
//  rsp      out        rsp_result_word                                valid&ready
//
// One request per clock while req_ready is high; every cell updates in parallel on a stream beat.
// The response is registered in the output register, or in the skid while the output is stalled.
// A one-entry skid stage behind the output register lets a request go in
// while a response is stalled; req_ready falls only while the skid is full.
// Reset clears all weights, lines and sums.
// ----------------------------------------------------------------------------
module weight_stationary_systolic_matmul_core #(
   parameter int ARRAY_DIM      = 8,
   parameter int BYTES_PER_WORD = 4,
   parameter int GROUPS         = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [2:0]                    req_weight_row,
   input  logic                          req_column_group,
   input  logic [wssm_pkg::WORD_W-1:0]   req_data_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wssm_pkg::WORD_W-1:0]   rsp_result_word
);

   localparam int BW = wssm_pkg::BYTE_W;

   logic                req_xfer;
   wssm_pkg::step_type  step;

   logic [ARRAY_DIM-1:0][BW-1:0]                     feed;
   logic [ARRAY_DIM-1:0][ARRAY_DIM-1:0][BW-1:0]      act_w;
   logic [ARRAY_DIM-1:0][ARRAY_DIM-1:0][wssm_pkg::SUM_W-1:0] sum_w;
   logic [ARRAY_DIM-1:0][BW-1:0]                     bottom_lo;
   logic [ARRAY_DIM-1:0][BW-1:0]                     diag_cur;
   logic [ARRAY_DIM-1:0][BW-1:0]                     diag_next;

   logic [2:0][wssm_pkg::WORD_W-1:0] cur_words;
   logic [wssm_pkg::WORD_W-1:0]      stream_word;
   logic [1:0]                       nxt_grp;
   logic [wssm_pkg::WORD_W-1:0]      result_in;

   logic                        rsp_valid_ff;
   logic [wssm_pkg::WORD_W-1:0] rsp_word_ff;
   logic                        skid_valid_ff;
   logic [wssm_pkg::WORD_W-1:0] skid_word_ff;
   logic                        out_load;

   assign req_xfer = req_valid && req_ready;

   assign step.load   = req_xfer && (req_mode == wssm_pkg::MODE_LOAD);
   assign step.queue  = req_xfer && (req_mode == wssm_pkg::MODE_QUEUE);
   assign step.stream = req_xfer && (req_mode == wssm_pkg::MODE_STREAM);
   assign step.group  = req_column_group;

   wssm_skew #(
      .ARRAY_DIM      (ARRAY_DIM),
      .BYTES_PER_WORD (BYTES_PER_WORD),
      .GROUPS         (GROUPS)
   ) u_skew (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_word (req_data_word),
      .feed      (feed)
   );

   genvar r, c;
   generate
      for (r = 0; r < ARRAY_DIM; r++) begin : g_row
         logic row_hit;
         assign row_hit = (32'(req_weight_row) == r);

         for (c = 0; c < ARRAY_DIM; c++) begin : g_col
            localparam int GRP_C = c / BYTES_PER_WORD;
            localparam int POS_C = c % BYTES_PER_WORD;

            wssm_pkg::cell_ctrl_type ctrl;
            logic [BW-1:0]           act_left;
            logic [wssm_pkg::SUM_W-1:0] sum_above;

            assign ctrl.beat    = step.stream;
            assign ctrl.wt_load = step.load && row_hit
                               && (req_column_group ? (GRP_C == 1) : (GRP_C == 0));

            if (c == 0) begin : g_left
               assign act_left = feed[r];
            end else begin : g_mid
               assign act_left = act_w[r][c-1];
            end

            if (r == 0) begin : g_top
               assign sum_above = '0;
            end else begin : g_below
               assign sum_above = sum_w[r-1][c];
            end

            if (r == ARRAY_DIM - 1) begin : g_bot
               wssm_cell #(
                  .FIRST_COL (c == 0)
               ) u_cell (
                  .clock     (clock),
                  .reset     (reset),
                  .ctrl      (ctrl),
                  .wt_byte   (req_data_word[BW*(BYTES_PER_WORD-1-POS_C) +: BW]),
                  .act_left  (act_left),
                  .sum_above (sum_above),
                  .act_out   (act_w[r][c]),
                  .sum_out   (sum_w[r][c]),
                  .sum_lo_in (bottom_lo[c])
               );
            end else begin : g_inner
               wssm_cell #(
                  .FIRST_COL (c == 0)
               ) u_cell (
                  .clock     (clock),
                  .reset     (reset),
                  .ctrl      (ctrl),
                  .wt_byte   (req_data_word[BW*(BYTES_PER_WORD-1-POS_C) +: BW]),
                  .act_left  (act_left),
                  .sum_above (sum_above),
                  .act_out   (act_w[r][c]),
                  .sum_out   (sum_w[r][c]),
                  .sum_lo_in ()
               );
            end
         end
      end
   endgenerate

   wssm_deskew #(
      .ARRAY_DIM (ARRAY_DIM)
   ) u_deskew (
      .clock     (clock),
      .reset     (reset),
      .beat      (step.stream),
      .bottom_lo (bottom_lo),
      .diag_cur  (diag_cur),
      .diag_next (diag_next)
   );

   // pack output bytes; columns off the array read as zero
   genvar g, k;
   generate
      for (g = 0; g < 3; g++) begin : g_grp
         for (k = 0; k < BYTES_PER_WORD; k++) begin : g_byte
            localparam int COL = g * BYTES_PER_WORD + k;
            if (COL < ARRAY_DIM) begin : g_on
               assign cur_words[g][BW*(BYTES_PER_WORD-1-k) +: BW] = diag_cur[COL];
            end else begin : g_off
               assign cur_words[g][BW*(BYTES_PER_WORD-1-k) +: BW] = '0;
            end
         end
         if (BYTES_PER_WORD < 4) begin : g_pad
            assign cur_words[g][wssm_pkg::WORD_W-1:BW*BYTES_PER_WORD] = '0;
         end
      end

      for (k = 0; k < BYTES_PER_WORD; k++) begin : g_sbyte
         if (k < ARRAY_DIM) begin : g_on
            assign stream_word[BW*(BYTES_PER_WORD-1-k) +: BW] = diag_next[k];
         end else begin : g_off
            assign stream_word[BW*(BYTES_PER_WORD-1-k) +: BW] = '0;
         end
      end
      if (BYTES_PER_WORD < 4) begin : g_spad
         assign stream_word[wssm_pkg::WORD_W-1:BW*BYTES_PER_WORD] = '0;
      end
   endgenerate

   // group after the one being queued, modulo the group count
   always_comb begin
      if (GROUPS == 1) begin
         nxt_grp = 2'd0;
      end else if (req_column_group && (GROUPS == 2)) begin
         nxt_grp = 2'd0;
      end else if (req_column_group) begin
         nxt_grp = 2'd2;
      end else begin
         nxt_grp = 2'd1;
      end
   end

   always_comb begin
      unique case (req_mode)
         wssm_pkg::MODE_QUEUE:  result_in = cur_words[nxt_grp];
         wssm_pkg::MODE_STREAM: result_in = stream_word;
         default:               result_in = '0;
      endcase
   end

   // output register with one-entry skid
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= req_xfer;
         end
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= skid_valid_ff ? skid_word_ff : result_in;
      end else if (req_xfer) begin
         skid_word_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a response while output register is empty");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("request transfer during stall not captured in skid");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && skid_valid_ff) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output register");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_mode == wssm_pkg::MODE_LOAD) |=>
         (skid_valid_ff ? (skid_word_ff == '0) : (rsp_word_ff == '0)))
      else $error("weight load produced a non-zero response");

endmodule

>>> tb/sv/weight_stationary_systolic_matmul_core_tb.sv
// ----------------------------------------------------------------------------
// weight_stationary_systolic_matmul_core_tb
// Self-checking bench for the weight-stationary int8 systolic matmul core.
// Weight loads, queue steps, stream beats and the unused mode are sent with
// bursty valid and a varying response stall pattern. Every transfer is run
// through a local copy of the array (weights, skew line, cells, sums and
// deskew line), and each response word is checked against it in order.
// ----------------------------------------------------------------------------
module weight_stationary_systolic_matmul_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM = 8;
   localparam int BPW = 4;
   localparam int GRP = 2;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int READY_ALWAYS   = 0;
   localparam int READY_PERIODIC = 1;
   localparam int READY_RANDOM   = 2;

   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [1:0]                  mode;
      logic [2:0]                  weight_row;
      logic                        column_group;
      logic [wssm_pkg::WORD_W-1:0] data_word;
   } matmul_req_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_mode = '0;
   logic [2:0]                  req_weight_row = '0;
   logic                        req_column_group = 1'b0;
   logic [wssm_pkg::WORD_W-1:0] req_data_word = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [wssm_pkg::WORD_W-1:0] rsp_result_word;

   weight_stationary_systolic_matmul_core #(
      .ARRAY_DIM      (DIM),
      .BYTES_PER_WORD (BPW),
      .GROUPS         (GRP)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_weight_row   (req_weight_row),
      .req_column_group (req_column_group),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_word  (rsp_result_word)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- array copy
   logic [7:0]  weights   [DIM][DIM];
   logic [7:0]  skew_line [DIM][DIM];
   logic [7:0]  cell_in   [DIM][DIM];
   logic [31:0] psum      [DIM][DIM];
   logic [7:0]  deskew    [DIM][DIM];

   matmul_req_type              req_backlog[$];
   logic [wssm_pkg::WORD_W-1:0] expected_words[$];

   int fail_count = 0;
   int rsp_checked = 0;
   int mode_count [4] = '{0, 0, 0, 0};

   // write one group of rows onto the skew diagonal
   function automatic void skew_in_group(int grp, logic [wssm_pkg::WORD_W-1:0] word);
      int r;
      for (int k = 0; k < BPW; k++) begin
         r = grp * BPW + k;
         if (r < DIM)
            skew_line[r][DIM-1-r] = word[8*(BPW-1-k) +: 8];
      end
   endfunction

   function automatic logic [wssm_pkg::WORD_W-1:0] deskewed_bytes(int first);
      logic [wssm_pkg::WORD_W-1:0] res;
      int c;
      res = '0;
      for (int k = 0; k < BPW; k++) begin
         c = first + k;
         if (c < DIM)
            res[8*(BPW-1-k) +: 8] = deskew[DIM-1-c][c];
      end
      return res;
   endfunction

   function automatic logic [wssm_pkg::WORD_W-1:0] predict_result_word(
      logic [1:0]                  mode,
      logic [2:0]                  row,
      logic                        grp,
      logic [wssm_pkg::WORD_W-1:0] word);
      logic [wssm_pkg::WORD_W-1:0] res;
      logic signed [15:0] prod;
      logic [31:0] above;
      int g;
      int c;
      res = '0;
      g = grp;
      case (mode)
         wssm_pkg::MODE_LOAD: begin
            if (row < DIM) begin
               for (int k = 0; k < BPW; k++) begin
                  c = g * BPW + k;
                  if (c < DIM)
                     weights[row][c] = word[8*(BPW-1-k) +: 8];
               end
            end
         end
         wssm_pkg::MODE_QUEUE: begin
            skew_in_group(g, word);
            res = deskewed_bytes(((g + 1) % GRP) * BPW);
         end
         wssm_pkg::MODE_STREAM: begin
            skew_in_group(GRP - 1, word);
            // skew line shifts right; its leftmost entry is left as it was
            for (int r = 0; r < DIM; r++) begin
               cell_in[r][0] = skew_line[r][DIM-1];
               for (int cc = DIM - 1; cc > 0; cc--)
                  skew_line[r][cc] = skew_line[r][cc-1];
            end
            // bottom row first so each cell still sees last beat's sum above
            for (int r = DIM - 1; r >= 0; r--) begin
               for (int cc = 0; cc < DIM; cc++) begin
                  above = (r > 0) ? psum[r-1][cc] : 32'd0;
                  prod = $signed(cell_in[r][cc]) * $signed(weights[r][cc]);
                  psum[r][cc] = {{16{prod[15]}}, prod} + above;
               end
            end
            for (int r = 0; r < DIM; r++)
               for (int cc = DIM - 1; cc > 0; cc--)
                  cell_in[r][cc] = cell_in[r][cc-1];
            for (int cc = 0; cc < DIM; cc++) begin
               for (int r = DIM - 1; r > 0; r--)
                  deskew[r][cc] = deskew[r-1][cc];
               deskew[0][cc] = psum[DIM-1][cc][7:0];
            end
            res = deskewed_bytes(0);
         end
         default: ;  // unused mode: nothing changes
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------ stimulus
   function automatic void enqueue_req(logic [1:0] mode, int row, int grp,
                                       logic [wssm_pkg::WORD_W-1:0] word);
      matmul_req_type item;
      item.mode         = mode;
      item.weight_row   = row[2:0];
      item.column_group = grp[0];
      item.data_word    = word;
      req_backlog.push_back(item);
   endfunction

   // random word, now and then made of extreme bytes only
   function automatic logic [wssm_pkg::WORD_W-1:0] rand_word();
      logic [wssm_pkg::WORD_W-1:0] w;
      w = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         for (int k = 0; k < BPW; k++) begin
            case ($urandom_range(0, 3))
               0:       w[8*k +: 8] = 8'h80;
               1:       w[8*k +: 8] = 8'h7f;
               2:       w[8*k +: 8] = 8'hff;
               default: w[8*k +: 8] = 8'h00;
            endcase
         end
      end
      return w;
   endfunction

   // -------------------------------------------------------------------- driver
   int             burst_left = 0;
   int             gap_left = 0;
   matmul_req_type drive_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_words.push_back(predict_result_word(req_mode, req_weight_row,
                                                         req_column_group, req_data_word));
            mode_count[req_mode] = mode_count[req_mode] + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               drive_item = req_backlog.pop_front();
               req_mode         <= drive_item.mode;
               req_weight_row   <= drive_item.weight_row;
               req_column_group <= drive_item.column_group;
               req_data_word    <= drive_item.data_word;
               req_valid        <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------- monitor
   int                          ready_style = READY_ALWAYS;
   int                          style_left = 0;
   int                          stall_period = 4;
   int                          ready_pct = 50;
   int                          phase = 0;
   logic [wssm_pkg::WORD_W-1:0] want_word;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response transfer: result_word=%h", rsp_result_word);
               fail_count = fail_count + 1;
            end else begin
               want_word = expected_words.pop_front();
               rsp_checked = rsp_checked + 1;
               if (rsp_result_word !== want_word) begin
                  $error("result_word mismatch: expected %h, actual %h",
                         want_word, rsp_result_word);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (style_left == 0) begin
            ready_style  <= $urandom_range(READY_ALWAYS, READY_RANDOM);
            stall_period <= $urandom_range(2, 12);
            ready_pct    <= $urandom_range(20, 90);
            style_left   <= $urandom_range(20, 200);
         end else begin
            style_left <= style_left - 1;
         end
         phase <= phase + 1;
         case (ready_style)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_PERIODIC: rsp_ready <= (phase % stall_period) != 0;
            default:        rsp_ready <= $urandom_range(0, 99) < ready_pct;
         endcase
      end
   end

   // ------------------------------------------------------------------ watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles with no transfer", idle_cycles);
         $display("[weight_stationary_systolic_matmul_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------- test flow
   initial begin
      int directed_n;
      int pick;
      int whole_matrix;

      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            weights[r][c]   = '0;
            skew_line[r][c] = '0;
            cell_in[r][c]   = '0;
            psum[r][c]      = '0;
            deskew[r][c]    = '0;
         end
      end

      // directed: extreme weights and inputs, every mode, ignored fields set
      enqueue_req(wssm_pkg::MODE_LOAD,   0, 0, 32'h807f_ff01);
      enqueue_req(wssm_pkg::MODE_LOAD,   0, 1, 32'hff00_807f);
      enqueue_req(wssm_pkg::MODE_LOAD,   7, 0, 32'h7f7f_7f7f);
      enqueue_req(wssm_pkg::MODE_LOAD,   7, 1, 32'h8080_8080);
      enqueue_req(wssm_pkg::MODE_LOAD,   5, 0, 32'hffff_ffff);
      enqueue_req(wssm_pkg::MODE_QUEUE,  0, 0, 32'h8080_8080);
      enqueue_req(wssm_pkg::MODE_QUEUE,  7, 1, 32'h7f7f_7f7f);
      enqueue_req(wssm_pkg::MODE_STREAM, 7, 1, 32'hffff_ffff);
      enqueue_req(MODE_UNUSED,           7, 1, 32'hffff_ffff);
      enqueue_req(wssm_pkg::MODE_QUEUE,  3, 0, 32'h7f80_7f80);
      enqueue_req(wssm_pkg::MODE_STREAM, 0, 0, 32'h0000_0000);
      repeat (10)
         enqueue_req(wssm_pkg::MODE_STREAM, $urandom_range(0, 7), $urandom_range(0, 1),
                     rand_word());
      enqueue_req(MODE_UNUSED, 0, 0, 32'h0000_0000);
      directed_n = req_backlog.size();

      // random: mostly weight reloads and stream runs, some raw noise
      while (req_backlog.size() < directed_n + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(1, 8))
               enqueue_req(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                           $urandom_range(0, 1), rand_word());
         end else if (pick <= 2) begin
            whole_matrix = $urandom_range(0, 1);
            for (int r = 0; r < DIM; r++)
               for (int g = 0; g < GRP; g++)
                  if (whole_matrix != 0 || $urandom_range(0, 3) == 0)
                     enqueue_req(wssm_pkg::MODE_LOAD, r, g, rand_word());
         end else begin
            repeat ($urandom_range(4, 24)) begin
               if ($urandom_range(0, 3) != 0)
                  enqueue_req(wssm_pkg::MODE_QUEUE, $urandom_range(0, 7), 0, rand_word());
               if ($urandom_range(0, 3) == 0)
                  enqueue_req(wssm_pkg::MODE_QUEUE, $urandom_range(0, 7), 1, rand_word());
               enqueue_req(wssm_pkg::MODE_STREAM, $urandom_range(0, 7),
                           $urandom_range(0, 1), rand_word());
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      // let any stray response show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d weight loads, %0d queue steps, %0d stream beats, %0d unused-mode items",
               mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("checked %0d responses, %0d failures", rsp_checked, fail_count);
      if (fail_count == 0)
         $display("[weight_stationary_systolic_matmul_core] OK");
      else
         $display("[weight_stationary_systolic_matmul_core] ERROR");
      $finish;
   end

endmodule
